FILE: rtl/core/homogeneous_point_transform_macros.svh
// assertion macros for the homogeneous point transform
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH

// same-cycle implication, disabled during reset
`define HPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpt same-cycle check failed");

// next-cycle implication, disabled during reset
`define HPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpt next-cycle check failed");

`endif

FILE: rtl/core/hpt_pkg.sv
// shared types, widths and constants of the homogeneous point transform
`default_nettype none
package hpt_pkg;

    localparam int PT_W            = 48;
    localparam int COEF_W          = 32;
    localparam int COEF_FRAC_BITS  = 20;
    localparam int POINT_FRAC_BITS = 16;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_SEL_W       = 3;
    localparam int NUM_REGS        = 8;
    localparam int NUM_ROWS        = 4;
    localparam int NUM_COORD       = 3;

    localparam int PT_LO_W  = PT_W / 2;
    localparam int PT_HI_W  = PT_W - PT_LO_W;
    localparam int PP_LO_W  = COEF_W + PT_LO_W + 1;
    localparam int PP_HI_W  = COEF_W + PT_HI_W;
    localparam int PROD_W   = COEF_W + PT_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int MAG_W    = ACC_W - 1;
    localparam int NUM_W    = MAG_W + POINT_FRAC_BITS;
    localparam int Q_BITS   = PT_W + 1;
    localparam int CMP_W    = MAG_W + Q_BITS;

    // register indexes
    localparam logic [CFG_SEL_W-1:0] REG_ROW0_C01 = 3'd0;
    localparam logic [CFG_SEL_W-1:0] REG_ROW1_C01 = 3'd2;
    localparam logic [CFG_SEL_W-1:0] REG_ROW2_C23 = 3'd5;
    localparam logic [CFG_SEL_W-1:0] REG_ROW3_C23 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_LAST     = 4'(NUM_REGS - 1);

    localparam logic [CFG_DATA_W-1:0] COEF_ONE = 64'(1) << COEF_FRAC_BITS;

    typedef struct packed {
        logic signed [PT_W-1:0] x_in;
        logic signed [PT_W-1:0] y_in;
        logic signed [PT_W-1:0] z_in;
    } point_t;

    typedef struct packed {
        logic signed [PT_W-1:0] x_out;
        logic signed [PT_W-1:0] y_out;
        logic signed [PT_W-1:0] z_out;
        logic                   passed_through;
        logic                   w_zero;
        logic                   saturated;
    } result_t;

    typedef logic [NUM_ROWS-1:0][NUM_ROWS-1:0][COEF_W-1:0] coef_mat_t;
    typedef logic [NUM_ROWS-1:0][NUM_COORD-1:0][PROD_W-1:0] term_arr_t;

    typedef struct packed {
        logic valid;
        logic pass;
    } pipe_ctl_t;

    typedef struct packed {
        logic                 valid;
        logic                 pass;
        logic                 wz;
        logic [NUM_COORD-1:0] ovf;
        logic [NUM_COORD-1:0] qneg;
        logic [NUM_COORD-1:0] nneg;
        logic [NUM_COORD-1:0] nzero;
    } div_ctl_t;

    typedef struct packed {
        logic [NUM_COORD-1:0][NUM_W-1:0]  rem;
        logic [MAG_W-1:0]                 den;
        logic [NUM_COORD-1:0][Q_BITS-1:0] quo;
        div_ctl_t                         ctl;
    } div_stage_t;

    function automatic logic [CFG_DATA_W-1:0] cfg_reset_value(input logic [CFG_SEL_W-1:0] sel);
        logic [CFG_DATA_W-1:0] val;
        unique case (sel) inside
            REG_ROW0_C01, REG_ROW2_C23: val = COEF_ONE;
            REG_ROW1_C01, REG_ROW3_C23: val = COEF_ONE << COEF_W;
            default:                    val = '0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/hpt_mult.sv
// coefficient by coordinate products, split in two halves over two stages
`default_nettype none
module hpt_mult (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               point_valid,
    input  wire hpt_pkg::point_t    point,
    input  wire hpt_pkg::coef_mat_t coef,
    output hpt_pkg::term_arr_t      term,
    output hpt_pkg::pipe_ctl_t      ctl
);

    logic [hpt_pkg::NUM_ROWS-1:0][hpt_pkg::NUM_COORD-1:0][hpt_pkg::PP_LO_W-1:0] pp_lo_reg;
    logic [hpt_pkg::NUM_ROWS-1:0][hpt_pkg::NUM_COORD-1:0][hpt_pkg::PP_LO_W-1:0] pp_lo_next;
    logic [hpt_pkg::NUM_ROWS-1:0][hpt_pkg::NUM_COORD-1:0][hpt_pkg::PP_HI_W-1:0] pp_hi_reg;
    logic [hpt_pkg::NUM_ROWS-1:0][hpt_pkg::NUM_COORD-1:0][hpt_pkg::PP_HI_W-1:0] pp_hi_next;
    logic [hpt_pkg::NUM_COORD-1:0][hpt_pkg::PT_W-1:0] coord;
    hpt_pkg::pipe_ctl_t ctl1_reg, ctl1_next;
    hpt_pkg::term_arr_t term_reg, term_next;
    hpt_pkg::pipe_ctl_t ctl2_reg;

    always_comb
    begin
        coord[0] = point.x_in;
        coord[1] = point.y_in;
        coord[2] = point.z_in;
        for (int r = 0; r < hpt_pkg::NUM_ROWS; r++)
        begin
            for (int j = 0; j < hpt_pkg::NUM_COORD; j++)
            begin
                pp_lo_next[r][j] = $signed(coef[r][j])
                                 * $signed({1'b0, coord[j][hpt_pkg::PT_LO_W-1:0]});
                pp_hi_next[r][j] = $signed(coef[r][j])
                                 * $signed(coord[j][hpt_pkg::PT_W-1:hpt_pkg::PT_LO_W]);
            end
        end
        ctl1_next.valid = point_valid;
        ctl1_next.pass  = (point == '0);
    end

    // recombine the halves into exact products
    always_comb
    begin
        for (int r = 0; r < hpt_pkg::NUM_ROWS; r++)
        begin
            for (int j = 0; j < hpt_pkg::NUM_COORD; j++)
            begin
                term_next[r][j] = (hpt_pkg::PROD_W'($signed(pp_hi_reg[r][j]))
                                   << hpt_pkg::PT_LO_W)
                                + hpt_pkg::PROD_W'($signed(pp_lo_reg[r][j]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            term_reg  <= term_next;
        end
    end

    assign term = term_reg;
    assign ctl  = ctl2_reg;

endmodule
`default_nettype wire

FILE: rtl/core/hpt_accum.sv
// row sums, sign and magnitude split, quotient range check
`default_nettype none
module hpt_accum (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire hpt_pkg::term_arr_t term,
    input  wire hpt_pkg::pipe_ctl_t ctl,
    input  wire hpt_pkg::coef_mat_t coef,
    output hpt_pkg::div_stage_t     stage
);

    logic [hpt_pkg::NUM_ROWS-1:0][hpt_pkg::ACC_W-1:0] acc_reg, acc_next;
    hpt_pkg::pipe_ctl_t  ctl_a_reg;
    hpt_pkg::div_stage_t mag_reg, mag_next;
    hpt_pkg::div_stage_t out_reg, out_next;
    logic [hpt_pkg::ACC_W-1:0] den_abs;
    logic [hpt_pkg::ACC_W-1:0] num_abs;
    logic                      dneg;

    // translation column uses the fixed w = 1
    always_comb
    begin
        for (int r = 0; r < hpt_pkg::NUM_ROWS; r++)
        begin
            acc_next[r] = hpt_pkg::ACC_W'($signed(term[r][0]))
                        + hpt_pkg::ACC_W'($signed(term[r][1]))
                        + hpt_pkg::ACC_W'($signed(term[r][2]))
                        + (hpt_pkg::ACC_W'($signed(coef[r][3])) << hpt_pkg::POINT_FRAC_BITS);
        end
    end

    always_comb
    begin
        mag_next           = '0;
        dneg               = acc_reg[3][hpt_pkg::ACC_W-1];
        den_abs            = dneg ? (-acc_reg[3]) : acc_reg[3];
        mag_next.den       = den_abs[hpt_pkg::MAG_W-1:0];
        mag_next.ctl.valid = ctl_a_reg.valid;
        mag_next.ctl.pass  = ctl_a_reg.pass;
        mag_next.ctl.wz    = (acc_reg[3] == '0);
        num_abs            = '0;
        for (int r = 0; r < hpt_pkg::NUM_COORD; r++)
        begin
            num_abs              = acc_reg[r][hpt_pkg::ACC_W-1] ? (-acc_reg[r]) : acc_reg[r];
            mag_next.rem[r]      = {num_abs[hpt_pkg::MAG_W-1:0],
                                    {hpt_pkg::POINT_FRAC_BITS{1'b0}}};
            mag_next.ctl.nneg[r] = acc_reg[r][hpt_pkg::ACC_W-1];
            mag_next.ctl.qneg[r] = acc_reg[r][hpt_pkg::ACC_W-1] ^ dneg;
            mag_next.ctl.nzero[r] = (acc_reg[r] == '0);
        end
    end

    // a quotient at or above 2^Q_BITS is flagged for clamping
    always_comb
    begin
        out_next = mag_reg;
        for (int r = 0; r < hpt_pkg::NUM_COORD; r++)
        begin
            out_next.ctl.ovf[r] = (hpt_pkg::CMP_W'(mag_reg.rem[r])
                                   >= (hpt_pkg::CMP_W'(mag_reg.den) << hpt_pkg::Q_BITS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            mag_reg   <= '0;
            out_reg   <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl;
            mag_reg   <= mag_next;
            out_reg   <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign stage = out_reg;

endmodule
`default_nettype wire

FILE: rtl/core/hpt_div.sv
// pipelined restoring divider, one quotient bit per stage, then round and clamp
`default_nettype none
module hpt_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire hpt_pkg::div_stage_t stage_in,
    output logic                     res_valid,
    output hpt_pkg::result_t         res
);

    localparam int QR_W = hpt_pkg::Q_BITS + 1;
    localparam logic [QR_W-1:0] POS_LIM = QR_W'((64'(1) << (hpt_pkg::PT_W - 1)) - 64'(1));
    localparam logic [QR_W-1:0] NEG_LIM = QR_W'(64'(1) << (hpt_pkg::PT_W - 1));

    hpt_pkg::div_stage_t stg_reg [hpt_pkg::Q_BITS];

    genvar s;
    generate
        for (s = 0; s < hpt_pkg::Q_BITS; s++)
        begin : g_bit
            localparam int B = hpt_pkg::Q_BITS - 1 - s;
            hpt_pkg::div_stage_t src;
            hpt_pkg::div_stage_t nxt;
            logic [hpt_pkg::CMP_W-1:0] dsh;

            if (s == 0)
            begin : g_first
                assign src = stage_in;
            end
            else
            begin : g_rest
                assign src = stg_reg[s-1];
            end

            always_comb
            begin
                nxt = src;
                dsh = hpt_pkg::CMP_W'(src.den) << B;
                for (int r = 0; r < hpt_pkg::NUM_COORD; r++)
                begin
                    if (hpt_pkg::CMP_W'(src.rem[r]) >= dsh)
                    begin
                        nxt.rem[r]    = src.rem[r] - dsh[hpt_pkg::NUM_W-1:0];
                        nxt.quo[r][B] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stg_reg[s] <= '0;
                end
                else if (en)
                begin
                    stg_reg[s] <= nxt;
                end
            end
        end
    endgenerate

    hpt_pkg::div_stage_t last;
    logic [hpt_pkg::NUM_COORD-1:0][QR_W-1:0] qr_reg, qr_next;
    hpt_pkg::div_ctl_t rctl_reg;
    hpt_pkg::result_t  res_reg, res_next;
    logic              res_valid_reg;
    logic [hpt_pkg::NUM_COORD-1:0][hpt_pkg::PT_W-1:0] coord;
    logic [QR_W-1:0]   lim;
    logic [QR_W-1:0]   m;
    logic              sat;

    assign last = stg_reg[hpt_pkg::Q_BITS-1];

    // round half away from zero on the magnitude
    always_comb
    begin
        for (int r = 0; r < hpt_pkg::NUM_COORD; r++)
        begin
            qr_next[r] = QR_W'(last.quo[r])
                       + QR_W'({last.rem[r], 1'b0} >= (hpt_pkg::NUM_W + 1)'(last.den));
        end
    end

    always_comb
    begin
        sat   = 1'b0;
        coord = '0;
        lim   = '0;
        m     = '0;
        for (int r = 0; r < hpt_pkg::NUM_COORD; r++)
        begin
            if (rctl_reg.wz)
            begin
                if (rctl_reg.nzero[r])
                begin
                    coord[r] = '0;
                end
                else
                begin
                    sat      = 1'b1;
                    coord[r] = rctl_reg.nneg[r] ? NEG_LIM[hpt_pkg::PT_W-1:0]
                                                : POS_LIM[hpt_pkg::PT_W-1:0];
                end
            end
            else
            begin
                lim = rctl_reg.qneg[r] ? NEG_LIM : POS_LIM;
                if (rctl_reg.ovf[r] || (qr_reg[r] > lim))
                begin
                    sat = 1'b1;
                    m   = lim;
                end
                else
                begin
                    m = qr_reg[r];
                end
                coord[r] = rctl_reg.qneg[r] ? (-m[hpt_pkg::PT_W-1:0]) : m[hpt_pkg::PT_W-1:0];
            end
        end
        res_next.x_out          = coord[0];
        res_next.y_out          = coord[1];
        res_next.z_out          = coord[2];
        res_next.passed_through = 1'b0;
        res_next.w_zero         = rctl_reg.wz;
        res_next.saturated      = sat;
        if (rctl_reg.pass)
        begin
            res_next                = '0;
            res_next.passed_through = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rctl_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rctl_reg      <= last.ctl;
            res_valid_reg <= rctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qr_reg  <= qr_next;
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

FILE: rtl/core/homogeneous_point_transform.sv
// top level of the homogeneous 4x4 point transform with perspective divide
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  point    | point_valid / point_ready  | point  (x_in, y_in, z_in)
//  result   | result_valid / result_ready| result (x_out .. saturated)
//  config   | cfg_wr_en                  | cfg_index, cfg_wdata
//
//  one point per cycle while the skid register is empty; path from accepted beat to
//  result beat: 2 product, 3 sum/range and 49 divider bit stages, round, clamp
//  the 49-stage restoring divider sets the depth: one quotient bit per stage
//  reset loads the identity matrix and empties every stage
//  a stalled result is held in a skid register; the whole pipe freezes while
//  it is full, so no beat is dropped or repeated
`default_nettype none
`include "homogeneous_point_transform_macros.svh"
module homogeneous_point_transform (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               point_valid,
    output logic                                    point_ready,
    input  wire hpt_pkg::point_t                    point,
    output logic                                    result_valid,
    input  wire logic                               result_ready,
    output hpt_pkg::result_t                        result,
    input  wire logic                               cfg_wr_en,
    input  wire logic [hpt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hpt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [hpt_pkg::CFG_DATA_W-1:0] cfg_reg [hpt_pkg::NUM_REGS];
    hpt_pkg::coef_mat_t  coef;
    hpt_pkg::term_arr_t  term;
    hpt_pkg::pipe_ctl_t  mult_ctl;
    hpt_pkg::div_stage_t div_in;
    logic                div_valid;
    hpt_pkg::result_t    div_res;
    logic                skid_full_reg, skid_full_next;
    hpt_pkg::result_t    skid_reg;
    logic                en;

    // configuration registers, writes past the last index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= hpt_pkg::cfg_reset_value(hpt_pkg::CFG_SEL_W'(i));
            end
        end
        else if (cfg_wr_en && (cfg_index <= hpt_pkg::REG_LAST))
        begin
            cfg_reg[cfg_index[hpt_pkg::CFG_SEL_W-1:0]] <= cfg_wdata;
        end
    end

    // row-major unpacking: two coefficients per register, low half first
    always_comb
    begin
        for (int r = 0; r < hpt_pkg::NUM_ROWS; r++)
        begin
            for (int c = 0; c < hpt_pkg::NUM_ROWS; c++)
            begin
                coef[r][c] = cfg_reg[hpt_pkg::CFG_SEL_W'(2 * r + (c >> 1))]
                                    [hpt_pkg::COEF_W * (c & 1) +: hpt_pkg::COEF_W];
            end
        end
    end

    // pipe moves whenever the skid register is empty
    assign en          = !skid_full_reg;
    assign point_ready = en;

    hpt_mult u_mult (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .point_valid (point_valid),
        .point       (point),
        .coef        (coef),
        .term        (term),
        .ctl         (mult_ctl)
    );

    hpt_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .term  (term),
        .ctl   (mult_ctl),
        .coef  (coef),
        .stage (div_in)
    );

    hpt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .stage_in  (div_in),
        .res_valid (div_valid),
        .res       (div_res)
    );

    // skid: catch the last stage's beat when the consumer holds off
    always_comb
    begin
        skid_full_next = skid_full_reg;
        if (!skid_full_reg)
        begin
            skid_full_next = div_valid && !result_ready;
        end
        else if (result_ready)
        begin
            skid_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            skid_reg <= div_res;
        end
    end

    assign result_valid = skid_full_reg || div_valid;
    assign result       = skid_full_reg ? skid_reg : div_res;

    // no-data points come out clean
    `HPT_ASSERT_IMP(a_pass_clean, clk, rst_n, result_valid && result.passed_through, result.x_out == '0 && result.y_out == '0 && result.z_out == '0 && !result.saturated && !result.w_zero)
    // zero w without clamping means every row sum was zero
    `HPT_ASSERT_IMP(a_wz_zero, clk, rst_n, result_valid && result.w_zero && !result.saturated, result.x_out == '0 && result.y_out == '0 && result.z_out == '0)
    // a held result keeps the pipe frozen
    `HPT_ASSERT_NXT(a_skid_hold, clk, rst_n, !point_ready && !result_ready, !point_ready)

endmodule
`default_nettype wire
